// ----- hdl/mca_pkg.sv -----
`timescale 1ns / 1ps

package mca_pkg;

	localparam int VAL_W      = 48;
	localparam int IDX_W      = 8;
	localparam int SUM_W      = VAL_W + 2;
	localparam int NUM_VALUES = 14;
	localparam int TBL_AW     = $clog2(NUM_VALUES);

	// table entry indexes
	localparam logic [TBL_AW-1:0] E_SPEED   = TBL_AW'(0);
	localparam logic [TBL_AW-1:0] E_NRM_A   = TBL_AW'(1);
	localparam logic [TBL_AW-1:0] E_SIDE_A  = TBL_AW'(2);
	localparam logic [TBL_AW-1:0] E_AXL_A   = TBL_AW'(3);
	localparam logic [TBL_AW-1:0] E_NRM_B   = TBL_AW'(4);
	localparam logic [TBL_AW-1:0] E_SIDE_B  = TBL_AW'(5);
	localparam logic [TBL_AW-1:0] E_AXL_B   = TBL_AW'(6);
	localparam logic [TBL_AW-1:0] E_NRM_C   = TBL_AW'(7);
	localparam logic [TBL_AW-1:0] E_SIDE_C  = TBL_AW'(8);
	localparam logic [TBL_AW-1:0] E_AXL_C   = TBL_AW'(9);
	localparam logic [TBL_AW-1:0] E_MASS    = TBL_AW'(10);
	localparam logic [TBL_AW-1:0] E_PITCH   = TBL_AW'(11);
	localparam logic [TBL_AW-1:0] E_HEADING = TBL_AW'(12);
	localparam logic [TBL_AW-1:0] E_ROLL    = TBL_AW'(13);

	localparam logic [IDX_W-1:0] IDX_PAUSE = IDX_W'(NUM_VALUES);

	// acceleration channels, in processing order
	localparam logic [1:0] CH_NORMAL = 2'd0;
	localparam logic [1:0] CH_SIDE   = 2'd1;
	localparam logic [1:0] CH_AXIAL  = 2'd2;

endpackage

// ----- hdl/mca_rec_if.sv -----
`timescale 1ns / 1ps

interface mca_rec_if;
	import mca_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [IDX_W-1:0]        ref_index;
	logic signed [VAL_W-1:0] ref_value;
	logic                    last_record;

	modport source (output valid, action, ref_index, ref_value, last_record, input ready);
	modport sink (input valid, action, ref_index, ref_value, last_record, output ready);

endinterface

// ----- hdl/mca_cue_if.sv -----
`timescale 1ns / 1ps

interface mca_cue_if;
	import mca_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] pitch_angle;
	logic signed [VAL_W-1:0] heading_angle;
	logic signed [VAL_W-1:0] roll_angle;
	logic signed [VAL_W-1:0] accel_side;
	logic signed [VAL_W-1:0] accel_normal;
	logic signed [VAL_W-1:0] accel_axial;
	logic                    motion_valid;

	modport source (output valid, pitch_angle, heading_angle, roll_angle, accel_side,
		accel_normal, accel_axial, motion_valid, input ready);
	modport sink (input valid, pitch_angle, heading_angle, roll_angle, accel_side,
		accel_normal, accel_axial, motion_valid, output ready);

endinterface

// ----- hdl/mca_sdiv.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module mca_sdiv #(
	parameter int NUM_W = 66,
	parameter int DEN_W = 47
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			// shift the quotient bit in where the numerator bit left
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ----- hdl/mca_smul.sv -----
`timescale 1ns / 1ps

// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
// Gives floor(a * b / 2^B_W).
module mca_smul #(
	parameter int A_W = 50,
	parameter int B_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           done,
	output logic [A_W-1:0] prod
);
	localparam int CNT_W = $clog2(B_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [A_W:0]     acc_q;
	logic [A_W:0]     sum;

	assign sum = acc_q + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			// drop the low bit each step; floor stays exact
			acc_q <= {1'b0, sum[A_W:1]};
			b_q   <= {1'b0, b_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q[A_W-1:0];

endmodule

// ----- hdl/motion_cue_accel_from_forces.sv -----
`timescale 1ns / 1ps

// Non-final record: taken in the idle state, which it does not leave; no result.
// Final record or timeout: the result is computed by the one-bit-per-cycle divider
// shared by the three channels, plus the
// bit-serial speed scaling and the divide-by-5 of the speed ratio.
// Records are not taken while a result is computed; one finished result may wait.
// Reset clears the value table, sets pause and empties the output register.
module motion_cue_accel_from_forces #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	mca_rec_if.sink  rec,
	mca_cue_if.source cue
);
	import mca_pkg::*;

	localparam int NW = SUM_W + FRAC_BITS;
	localparam int RW = FRAC_BITS + 3;
	localparam int DW = VAL_W - 1;

	localparam longint ONE_I   = longint'(1) << FRAC_BITS;
	localparam longint TENTH_I = (ONE_I + 5) / 10;

	localparam logic signed [VAL_W-1:0] FX_ONE  = VAL_W'(ONE_I);
	localparam logic signed [VAL_W-1:0] GS_MAX  = VAL_W'(ONE_I * 5);
	localparam logic signed [SUM_W-1:0] TENTH   = SUM_W'(TENTH_I);
	localparam logic signed [SUM_W-1:0] NTENTH  = -SUM_W'(TENTH_I);
	localparam logic [SUM_W-1:0]        MAG_LIM = SUM_W'(1) << (VAL_W - 1);
	localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_START = 9'b000000010,
		ST_RATIO = 9'b000000100,
		ST_LOAD  = 9'b000001000,
		ST_PREP  = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_SCALE = 9'b001000000,
		ST_STORE = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t                  state_q;
	logic [1:0]              ch_q;
	logic                    pause_q;
	logic signed [VAL_W-1:0] tbl_q [NUM_VALUES];
	logic                    out_v_q;

	logic [FRAC_BITS:0]      ratio_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        p_q;
	logic signed [VAL_W-1:0] res_n_q, res_s_q, res_a_q;
	logic signed [VAL_W-1:0] pitch_q, heading_q, roll_q, side_q, normal_q, axial_q;
	logic                    mvalid_q;

	logic                    rec_acc;
	logic                    out_load;
	logic                    gs_in_band;
	logic                    skip_scale;
	logic signed [SUM_W-1:0] sum_d;
	logic signed [SUM_W-1:0] snap_d;
	logic [SUM_W-1:0]        mag_d;
	logic [DW-1:0]           den_d;
	logic signed [VAL_W-1:0] sat_d;

	logic                    ratio_start, ratio_done;
	logic [RW-1:0]           ratio_quot;
	logic                    div_start, div_done;
	logic [NW-1:0]           div_quot;
	logic                    mul_start, mul_done;
	logic [SUM_W-1:0]        mul_prod;

	assign rec.ready = (state_q == ST_IDLE);
	assign rec_acc   = rec.valid && rec.ready;
	assign out_load  = (state_q == ST_DONE) && (!out_v_q || cue.ready);

	assign gs_in_band = (tbl_q[E_SPEED] > 0) && (tbl_q[E_SPEED] < GS_MAX);
	assign skip_scale = (ch_q == CH_NORMAL) || ratio_q[FRAC_BITS];
	assign den_d      = (tbl_q[E_MASS] > FX_ONE) ? tbl_q[E_MASS][DW-1:0] : FX_ONE[DW-1:0];

	always_comb begin
		case (ch_q)
			CH_NORMAL: sum_d = SUM_W'(tbl_q[E_NRM_A]) + SUM_W'(tbl_q[E_NRM_B])
				+ SUM_W'(tbl_q[E_NRM_C]);
			CH_SIDE: sum_d = SUM_W'(tbl_q[E_SIDE_A]) + SUM_W'(tbl_q[E_SIDE_B])
				+ SUM_W'(tbl_q[E_SIDE_C]);
			default: sum_d = SUM_W'(tbl_q[E_AXL_A]) + SUM_W'(tbl_q[E_AXL_B])
				+ SUM_W'(tbl_q[E_AXL_C]);
		endcase
	end

	always_comb begin
		snap_d = sum_q;
		// snap the normal channel out of the deadband
		if (ch_q == CH_NORMAL && sum_q >= NTENTH && sum_q <= TENTH) begin
			snap_d = sum_q[SUM_W-1] ? NTENTH : TENTH;
		end
		mag_d = snap_d[SUM_W-1] ? SUM_W'(-snap_d) : SUM_W'(snap_d);
	end

	always_comb begin
		if (neg_q) begin
			sat_d = (p_q > MAG_LIM) ? SAT_MIN : VAL_W'(-p_q);
		end else begin
			sat_d = (p_q >= MAG_LIM) ? SAT_MAX : VAL_W'(p_q);
		end
	end

	assign ratio_start = (state_q == ST_START) && gs_in_band;
	assign div_start   = (state_q == ST_PREP);
	assign mul_start   = (state_q == ST_DIV) && div_done && !skip_scale;

	mca_sdiv #(.NUM_W(RW), .DEN_W(3)) u_ratio_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ratio_start),
		.numer  (tbl_q[E_SPEED][RW-1:0]),
		.denom  (3'd5),
		.done   (ratio_done),
		.quot   (ratio_quot)
	);

	mca_sdiv #(.NUM_W(NW), .DEN_W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  ({mag_d, {FRAC_BITS{1'b0}}}),
		.denom  (den_d),
		.done   (div_done),
		.quot   (div_quot)
	);

	mca_smul #(.A_W(SUM_W), .B_W(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (div_quot[SUM_W-1:0]),
		.b      (ratio_q[FRAC_BITS-1:0]),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= CH_NORMAL;
			pause_q <= 1'b1;
			out_v_q <= 1'b0;
			for (int i = 0; i < NUM_VALUES; i++) begin
				tbl_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (cue.valid && cue.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (rec_acc) begin
						if (rec.action) begin
							pause_q <= 1'b1;
							state_q <= ST_START;
						end else begin
							if (rec.ref_index < IDX_PAUSE) begin
								tbl_q[rec.ref_index[TBL_AW-1:0]] <= rec.ref_value;
							end else if (rec.ref_index == IDX_PAUSE) begin
								pause_q <= (rec.ref_value >= FX_ONE)
									|| (rec.ref_value <= -FX_ONE);
							end
							if (rec.last_record) begin
								state_q <= ST_START;
							end
						end
					end
				end
				ST_START: begin
					ch_q    <= CH_NORMAL;
					state_q <= gs_in_band ? ST_RATIO : ST_LOAD;
				end
				ST_RATIO: begin
					if (ratio_done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= skip_scale ? ST_STORE : ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (mul_done) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (ch_q == CH_AXIAL) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			if (tbl_q[E_SPEED] <= 0) begin
				ratio_q <= '0;
			end else if (!gs_in_band) begin
				ratio_q <= FX_ONE[FRAC_BITS:0];
			end
		end
		if (state_q == ST_RATIO && ratio_done) begin
			ratio_q <= ratio_quot[FRAC_BITS:0];
		end
		if (state_q == ST_LOAD) begin
			sum_q <= sum_d;
		end
		if (state_q == ST_PREP) begin
			neg_q <= snap_d[SUM_W-1];
		end
		if (state_q == ST_DIV && div_done) begin
			p_q <= div_quot[SUM_W-1:0];
		end
		if (state_q == ST_SCALE && mul_done) begin
			p_q <= mul_prod;
		end
		if (state_q == ST_STORE) begin
			case (ch_q)
				CH_NORMAL: res_n_q <= sat_d;
				CH_SIDE:   res_s_q <= sat_d;
				default:   res_a_q <= sat_d;
			endcase
		end
		if (out_load) begin
			pitch_q   <= tbl_q[E_PITCH];
			heading_q <= tbl_q[E_HEADING];
			roll_q    <= tbl_q[E_ROLL];
			side_q    <= res_s_q;
			normal_q  <= res_n_q;
			axial_q   <= res_a_q;
			mvalid_q  <= !pause_q;
		end
	end

	assign cue.valid         = out_v_q;
	assign cue.pitch_angle   = pitch_q;
	assign cue.heading_angle = heading_q;
	assign cue.roll_angle    = roll_q;
	assign cue.accel_side    = side_q;
	assign cue.accel_normal  = normal_q;
	assign cue.accel_axial   = axial_q;
	assign cue.motion_valid  = mvalid_q;

	a_timeout_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_acc && rec.action) |=> pause_q)
		else $error("timeout did not set pause");

	a_end_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_acc && (rec.action || rec.last_record)) |=> (state_q == ST_START))
		else $error("final word did not start a result");

	a_table_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> ($stable(tbl_q[E_MASS]) && $stable(tbl_q[E_SPEED])))
		else $error("table changed during compute");

	a_result_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_v_q && (cue.motion_valid == !$past(pause_q))))
		else $error("result word or its valid flag wrong");

endmodule

// ----- tb/sv/motion_cue_checker.sv -----
`timescale 1ns / 1ps

module motion_cue_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	mca_rec_if   rec,
	mca_cue_if   cue,
	output int   errors,
	output int   pending
);
	import mca_pkg::*;

	typedef struct packed {
		logic signed [VAL_W-1:0] pitch;
		logic signed [VAL_W-1:0] heading;
		logic signed [VAL_W-1:0] roll;
		logic signed [VAL_W-1:0] side;
		logic signed [VAL_W-1:0] normal;
		logic signed [VAL_W-1:0] axial;
		logic                    motion_valid;
	} cue_t;

	localparam longint ONE   = longint'(1) << FRAC_BITS;
	localparam longint TENTH = (ONE + 5) / 10;
	localparam longint MAX48 = (longint'(1) << (VAL_W - 1)) - 1;
	localparam longint MIN48 = -MAX48 - 1;

	logic signed [VAL_W-1:0] force_tbl [NUM_VALUES];
	logic                    paused;
	cue_t                    cue_q [$];

	function automatic logic signed [VAL_W-1:0] sat48(longint v);
		if (v > MAX48)
			return VAL_W'(MAX48);
		if (v < MIN48)
			return VAL_W'(MIN48);
		return VAL_W'(v);
	endfunction

	// sum * 2^FRAC_BITS / mass on magnitudes, truncated toward zero
	function automatic longint mass_div(longint sum, longint den);
		logic [63:0]  m;
		logic [127:0] num;
		logic [127:0] q;
		m   = (sum < 0) ? -sum : sum;
		num = {64'd0, m} << FRAC_BITS;
		q   = num / {64'd0, den};
		return (sum < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic longint speed_scale(longint a, longint ratio);
		logic [63:0]  m;
		logic [127:0] p;
		m = (a < 0) ? -a : a;
		p = ({64'd0, m} * {64'd0, ratio}) >> FRAC_BITS;
		return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic cue_t cue_from_table();
		longint speed;
		longint ratio;
		longint den;
		longint s_n;
		longint s_s;
		longint s_a;
		cue_t   c;
		speed = force_tbl[E_SPEED];
		ratio = (speed <= 0) ? 0 : speed / 5;
		if (ratio > ONE)
			ratio = ONE;
		den = (force_tbl[E_MASS] > ONE) ? longint'(force_tbl[E_MASS]) : ONE;
		s_n = longint'(force_tbl[E_NRM_A]) + force_tbl[E_NRM_B] + force_tbl[E_NRM_C];
		s_s = longint'(force_tbl[E_SIDE_A]) + force_tbl[E_SIDE_B] + force_tbl[E_SIDE_C];
		s_a = longint'(force_tbl[E_AXL_A]) + force_tbl[E_AXL_B] + force_tbl[E_AXL_C];
		// snap the normal sum out of the deadband
		if (s_n >= -TENTH && s_n <= TENTH)
			s_n = (s_n < 0) ? -TENTH : TENTH;
		c.pitch        = force_tbl[E_PITCH];
		c.heading      = force_tbl[E_HEADING];
		c.roll         = force_tbl[E_ROLL];
		c.side         = sat48(speed_scale(mass_div(s_s, den), ratio));
		c.normal       = sat48(mass_div(s_n, den));
		c.axial        = sat48(speed_scale(mass_div(s_a, den), ratio));
		c.motion_valid = !paused;
		return c;
	endfunction

	task automatic check_field(string name, logic signed [VAL_W-1:0] want,
		logic signed [VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cue_t got;
		cue_t want;
		if (!arst_n) begin
			foreach (force_tbl[i])
				force_tbl[i] = '0;
			paused = 1'b1;
			cue_q.delete();
		end else begin
			if (cue.valid && cue.ready) begin
				got.pitch        = cue.pitch_angle;
				got.heading      = cue.heading_angle;
				got.roll         = cue.roll_angle;
				got.side         = cue.accel_side;
				got.normal       = cue.accel_normal;
				got.axial        = cue.accel_axial;
				got.motion_valid = cue.motion_valid;
				if (cue_q.size() == 0) begin
					$display("%0t: unexpected cue word: expected none, got %p", $time, got);
					errors++;
				end else begin
					want = cue_q.pop_front();
					check_field("pitch_angle", want.pitch, got.pitch);
					check_field("heading_angle", want.heading, got.heading);
					check_field("roll_angle", want.roll, got.roll);
					check_field("accel_side", want.side, got.side);
					check_field("accel_normal", want.normal, got.normal);
					check_field("accel_axial", want.axial, got.axial);
					check_field("motion_valid", want.motion_valid, got.motion_valid);
				end
			end
			if (rec.valid && rec.ready) begin
				if (rec.action) begin
					paused = 1'b1;
					cue_q.push_back(cue_from_table());
				end else begin
					if (rec.ref_index < NUM_VALUES)
						force_tbl[rec.ref_index[TBL_AW-1:0]] = rec.ref_value;
					else if (rec.ref_index == IDX_PAUSE)
						paused = (longint'(rec.ref_value) >= ONE) ||
							(longint'(rec.ref_value) <= -ONE);
					if (rec.last_record)
						cue_q.push_back(cue_from_table());
				end
			end
		end
		pending = cue_q.size();
	end

endmodule

// ----- tb/sv/motion_cue_accel_from_forces_tb.sv -----
`timescale 1ns / 1ps

module motion_cue_accel_from_forces_tb;
	import mca_pkg::*;

	localparam int FRAC_BITS    = 16;
	localparam int ITEMS        = 450;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 400;

	localparam logic ACT_RECORD  = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	localparam int     ONE   = 1 << FRAC_BITS;
	localparam int     TENTH = (ONE + 5) / 10;
	localparam longint MAX48 = (longint'(1) << (VAL_W - 1)) - 1;
	localparam longint MIN48 = -MAX48 - 1;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   items_sent;
	int   burst_left;
	int   idle_cycles;
	int   ready_run;
	logic ready_val;

	mca_rec_if rec ();
	mca_cue_if cue ();

	motion_cue_accel_from_forces #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rec   (rec),
		.cue   (cue)
	);

	motion_cue_checker #(
		.FRAC_BITS(FRAC_BITS)
	) u_cue_check (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rec),
		.cue    (cue),
		.errors (errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint spread(int unsigned span);
		longint v;
		v = longint'($urandom_range(0, span));
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value(logic [IDX_W-1:0] idx);
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return VAL_W'({$urandom, $urandom});
		if (pick == 1) begin
			case ($urandom_range(0, 3))
				0: return VAL_W'(MAX48);
				1: return VAL_W'(MIN48);
				2: return '0;
				default: return '1;
			endcase
		end
		// keep the link mostly unpaused
		if (idx == IDX_PAUSE)
			return (pick < 12) ? '0 : VAL_W'(spread(3 * ONE));
		if (idx == IDX_W'(E_SPEED))
			return (pick < 4) ? VAL_W'(spread(ONE))
				: VAL_W'(longint'($urandom_range(0, 8 * ONE)));
		if (idx == IDX_W'(E_MASS))
			return (pick < 4) ? VAL_W'(spread(ONE))
				: VAL_W'(longint'($urandom_range(ONE / 2, 40 * ONE)));
		if (pick < 6)
			return VAL_W'(spread(2 * TENTH));
		return VAL_W'(spread(200 * ONE));
	endfunction

	task automatic send(logic act, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] val,
		logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			case ($urandom_range(0, 15))
				0: gap = $urandom_range(20, 300);
				1, 2, 3, 4: gap = 0;
				default: gap = $urandom_range(1, 8);
			endcase
			if (gap > 0) begin
				rec.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		rec.valid       = 1'b1;
		rec.action      = act;
		rec.ref_index   = idx;
		rec.ref_value   = val;
		rec.last_record = last;
		do
			@(posedge clk);
		while (!rec.ready);
		if (act == ACT_TIMEOUT || idx <= IDX_PAUSE)
			items_sent++;
	endtask

	// receiver: short random stalls, long stalls, and long stretches of ready
	always @(negedge clk) begin
		if (ready_run == 0) begin
			case ($urandom_range(0, 7))
				0: begin
					ready_val = 1'b1;
					ready_run = $urandom_range(100, 300);
				end
				1, 2: begin
					ready_val = 1'b0;
					ready_run = $urandom_range(1, 40);
				end
				default: begin
					ready_val = 1'($urandom_range(0, 1));
					ready_run = $urandom_range(1, 6);
				end
			endcase
		end
		ready_run--;
		cue.ready = ready_val;
	end

	always @(posedge clk) begin
		if ((rec.valid && rec.ready) || (cue.valid && cue.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int n;
		logic [IDX_W-1:0] idx;
		arst_n          = 1'b0;
		rec.valid       = 1'b0;
		rec.action      = ACT_RECORD;
		rec.ref_index   = '0;
		rec.ref_value   = '0;
		rec.last_record = 1'b0;
		burst_left      = 0;
		items_sent      = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// cleared table while paused, then a timeout with junk fields
		send(ACT_RECORD, 8'd20, '0, 1'b1);
		send(ACT_TIMEOUT, 8'hff, '1, 1'b0);
		// just under 1.0 truncates to zero: unpause
		send(ACT_RECORD, IDX_PAUSE, VAL_W'(ONE - 1), 1'b0);
		send(ACT_RECORD, IDX_W'(E_SPEED), VAL_W'(10 * ONE), 1'b0);
		send(ACT_RECORD, IDX_W'(E_MASS), VAL_W'(-5 * ONE), 1'b0);
		send(ACT_RECORD, IDX_W'(E_SIDE_A), VAL_W'(MAX48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_SIDE_B), VAL_W'(MAX48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_SIDE_C), VAL_W'(MAX48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_AXL_A), VAL_W'(MIN48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_AXL_B), VAL_W'(MIN48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_AXL_C), VAL_W'(MIN48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_NRM_A), VAL_W'(-(ONE / 20)), 1'b0);
		send(ACT_RECORD, IDX_W'(E_PITCH), VAL_W'(MAX48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_HEADING), VAL_W'(MIN48), 1'b0);
		send(ACT_RECORD, IDX_W'(E_ROLL), VAL_W'(-1), 1'b1);
		// normal sum of exactly zero, then on either side of the lower deadband edge
		send(ACT_RECORD, IDX_W'(E_NRM_B), VAL_W'(ONE / 20), 1'b1);
		send(ACT_RECORD, IDX_W'(E_NRM_B), '0, 1'b0);
		send(ACT_RECORD, IDX_W'(E_NRM_A), VAL_W'(-TENTH), 1'b1);
		send(ACT_RECORD, IDX_W'(E_NRM_A), VAL_W'(-TENTH - 1), 1'b1);
		// negative speed, tiny mass
		send(ACT_RECORD, IDX_W'(E_SPEED), VAL_W'(-ONE), 1'b0);
		send(ACT_RECORD, IDX_W'(E_MASS), VAL_W'(ONE / 2), 1'b1);
		send(ACT_RECORD, IDX_W'(E_SPEED), VAL_W'(3 * ONE + 7), 1'b0);
		send(ACT_RECORD, IDX_W'(E_MASS), VAL_W'(2500 * ONE), 1'b1);
		send(ACT_RECORD, IDX_PAUSE, VAL_W'(-ONE), 1'b1);
		send(ACT_RECORD, IDX_PAUSE, '0, 1'b1);

		while (items_sent < ITEMS) begin
			case ($urandom_range(0, 9))
				0: send(ACT_TIMEOUT, IDX_W'($urandom), VAL_W'({$urandom, $urandom}),
					1'($urandom_range(0, 1)));
				1: begin
					n = $urandom_range(1, 4);
					repeat (n)
						send(ACT_RECORD, IDX_W'($urandom), VAL_W'({$urandom, $urandom}),
							1'($urandom_range(0, 1)));
				end
				default: begin
					n = $urandom_range(1, 16);
					for (int k = 0; k < n; k++) begin
						idx = IDX_W'($urandom_range(0, NUM_VALUES));
						// break the packet with a link timeout now and then
						if ($urandom_range(0, 29) == 0)
							send(ACT_TIMEOUT, idx, rand_value(idx), 1'b0);
						send(ACT_RECORD, idx, rand_value(idx), k == n - 1);
					end
				end
			endcase
		end

		@(negedge clk);
		rec.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
